// ===== rtl/msfs_pkg.sv =====
package msfs_pkg;

  // Channels that the snapshot carries, and channels that the supervisor looks at.
  localparam int CH_FIELDS = 4;
  localparam int CHANNELS  = 4;
  localparam int NCH       = (CHANNELS < CH_FIELDS) ? CHANNELS : CH_FIELDS;
  localparam int CH_IDX_W  = 2;

  localparam int TEMP_W = 18;
  localparam int ERR_W  = 19;
  localparam int INT_W  = 14;
  localparam int CNT_W  = 3;
  localparam int TICK_W = 32;
  localparam int SEQ_W  = 32;
  localparam int MODE_W = 3;

  // Sum of up to four channels, and the divider that averages it.
  localparam int SUM_W  = TEMP_W + 2;
  localparam int DIV_W  = SUM_W;
  localparam int DVS_W  = CNT_W;
  localparam int REM_W  = DVS_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [CNT_W-1:0]  MIN_VALID  = CNT_W'(2);
  localparam logic [INT_W-1:0]  NOMINAL_MS = INT_W'(200);
  localparam logic [TICK_W-1:0] MAX_GAP_MS = TICK_W'(10000);

  localparam logic [MODE_W-1:0] MODE_AVG = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CH1 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CH4 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  localparam logic [1:0] RS_IDLE     = 2'd0;
  localparam logic [1:0] RS_CONTROL  = 2'd1;
  localparam logic [1:0] RS_OVERTEMP = 2'd2;

  typedef enum logic [1:0] {
    REG_SETPOINT  = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_MODE      = 2'd2,
    REG_ENABLE    = 2'd3
  } reg_idx_t;

  localparam logic signed [TEMP_W-1:0] SETPOINT_RST  = TEMP_W'(2500);
  localparam logic signed [TEMP_W-1:0] THRESHOLD_RST = TEMP_W'(4800);

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic signed [TEMP_W-1:0] threshold;
    logic [MODE_W-1:0]        mode;
    logic                     enable;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

endpackage

// ===== rtl/msfs_cfg.sv =====
module msfs_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [1:0]                 wr_index,
  input  logic [msfs_pkg::TEMP_W-1:0] wr_data,
  output msfs_pkg::cfg_t             cfg
);

  msfs_pkg::cfg_t cfg_r;
  msfs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (msfs_pkg::reg_idx_t'(wr_index))
        msfs_pkg::REG_SETPOINT:  cfg_nxt.setpoint  = wr_data;
        msfs_pkg::REG_THRESHOLD: cfg_nxt.threshold = wr_data;
        msfs_pkg::REG_MODE:      cfg_nxt.mode      = wr_data[msfs_pkg::MODE_W-1:0];
        msfs_pkg::REG_ENABLE:    cfg_nxt.enable    = wr_data[0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint  <= msfs_pkg::SETPOINT_RST;
      cfg_r.threshold <= msfs_pkg::THRESHOLD_RST;
      cfg_r.mode      <= msfs_pkg::MODE_AVG;
      cfg_r.enable    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/msfs_div.sv =====
module msfs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  msfs_pkg::div_req_t req,
  output msfs_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [msfs_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [msfs_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [msfs_pkg::DIV_W-1:0]    quo_r, quo_nxt;
  logic [msfs_pkg::DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [msfs_pkg::REM_W-1:0]    rem_sh;
  logic                          fits;

  // Restoring division, one quotient bit per cycle. The dividend shifts out of
  // the top of quo_r while quotient bits shift in at the bottom.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r[msfs_pkg::REM_W-2:0], quo_r[msfs_pkg::DIV_W-1]};
    fits     = (rem_sh >= {1'b0, dvs_r});
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = msfs_pkg::DCNT_W'(msfs_pkg::DIV_W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_nxt = {quo_r[msfs_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == msfs_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/multi_sensor_feedback_supervisor_unit.sv =====
// Flow: an accepted snapshot is scanned channel by channel in S_SCAN; in average mode with
// enough valid channels it then passes S_DIVST and waits in S_DIV for the divider, then S_DONE.
// Throughput: one snapshot at a time; the next one is accepted only once S_DONE has handed
// its result to the output register, later while the previous result still waits there.
// Reset (rst_n low, synchronous) restores the registers to their defaults and clears the
// sequence and tick history and the over-temperature latch.
module multi_sensor_feedback_supervisor_unit (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [msfs_pkg::TEMP_W-1:0] in_temp_ch1,
  input  logic signed [msfs_pkg::TEMP_W-1:0] in_temp_ch2,
  input  logic signed [msfs_pkg::TEMP_W-1:0] in_temp_ch3,
  input  logic signed [msfs_pkg::TEMP_W-1:0] in_temp_ch4,
  input  logic [msfs_pkg::CH_FIELDS-1:0]     in_valid_mask,
  input  logic [msfs_pkg::TICK_W-1:0]        in_tick_ms,
  input  logic [msfs_pkg::SEQ_W-1:0]         in_sequence_req,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_run,
  output logic                               out_pid_clear,
  output logic                               out_feedback_ok,
  output logic signed [msfs_pkg::TEMP_W-1:0] out_feedback_temp,
  output logic signed [msfs_pkg::ERR_W-1:0]  out_control_error,
  output logic [msfs_pkg::INT_W-1:0]         out_interval_ms,
  output logic [msfs_pkg::CNT_W-1:0]         out_chan_count,
  output logic [1:0]                         out_run_state,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [msfs_pkg::TEMP_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIVST,
    S_DIV,
    S_DONE
  } state_t;

  msfs_pkg::cfg_t     cfg;
  msfs_pkg::div_req_t div_req;
  msfs_pkg::div_rsp_t div_rsp;

  state_t state_r, state_nxt;

  logic signed [msfs_pkg::TEMP_W-1:0] temp_r   [msfs_pkg::CH_FIELDS];
  logic signed [msfs_pkg::TEMP_W-1:0] temp_nxt [msfs_pkg::CH_FIELDS];
  logic [msfs_pkg::CH_FIELDS-1:0]     mask_r, mask_nxt;
  logic [msfs_pkg::TICK_W-1:0]        tick_r, tick_nxt;
  logic [msfs_pkg::SEQ_W-1:0]         last_round_r, last_round_nxt;
  logic [msfs_pkg::TICK_W-1:0]        last_tick_r, last_tick_nxt;
  logic                               ot_latch_r, ot_latch_nxt;
  logic [msfs_pkg::CH_IDX_W-1:0]      idx_r, idx_nxt;
  logic [msfs_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [msfs_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [msfs_pkg::TEMP_W-1:0] ext_r, ext_nxt;
  logic                               fix_ok_r, fix_ok_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_run_r, out_run_nxt;
  logic                               out_rst_r, out_rst_nxt;
  logic                               out_ok_r, out_ok_nxt;
  logic signed [msfs_pkg::TEMP_W-1:0] out_fb_r, out_fb_nxt;
  logic signed [msfs_pkg::ERR_W-1:0]  out_err_r, out_err_nxt;
  logic [msfs_pkg::INT_W-1:0]         out_int_r, out_int_nxt;
  logic [msfs_pkg::CNT_W-1:0]         out_cnt_r, out_cnt_nxt;
  logic [1:0]                         out_rs_r, out_rs_nxt;

  logic                               mode_avg, mode_fixed;
  logic [msfs_pkg::CH_IDX_W-1:0]      fix_ch;

  assign cfg_ready = 1'b1;

  msfs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  msfs_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign mode_avg   = (cfg.mode == msfs_pkg::MODE_AVG) || (cfg.mode == msfs_pkg::MODE_UNUSED);
  assign mode_fixed = (cfg.mode >= msfs_pkg::MODE_CH1) && (cfg.mode <= msfs_pkg::MODE_CH4);
  assign fix_ch     = msfs_pkg::CH_IDX_W'(cfg.mode - msfs_pkg::MODE_CH1);

  assign in_ready = (state_r == S_IDLE);

  // The divider works on the magnitude of the sum, so the quotient truncates
  // toward zero once the sign is put back.
  assign div_req.start    = (state_r == S_DIVST);
  assign div_req.dividend = sum_r[msfs_pkg::SUM_W-1] ? msfs_pkg::DIV_W'(-sum_r)
                                                     : msfs_pkg::DIV_W'(sum_r);
  assign div_req.divisor  = cnt_r;

  always_comb begin
    logic signed [msfs_pkg::TEMP_W-1:0] t_cur;
    logic                               v_cur;
    logic                               ok;
    logic                               stop;
    logic signed [msfs_pkg::TEMP_W-1:0] fb;
    logic signed [msfs_pkg::TEMP_W-1:0] avg;
    logic [msfs_pkg::TICK_W-1:0]        gap;

    state_nxt      = state_r;
    temp_nxt       = temp_r;
    mask_nxt       = mask_r;
    tick_nxt       = tick_r;
    last_round_nxt = last_round_r;
    last_tick_nxt  = last_tick_r;
    ot_latch_nxt   = ot_latch_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    ext_nxt        = ext_r;
    fix_ok_nxt     = fix_ok_r;
    out_valid_nxt  = out_valid_r;
    out_run_nxt    = out_run_r;
    out_rst_nxt    = out_rst_r;
    out_ok_nxt     = out_ok_r;
    out_fb_nxt     = out_fb_r;
    out_err_nxt    = out_err_r;
    out_int_nxt    = out_int_r;
    out_cnt_nxt    = out_cnt_r;
    out_rs_nxt     = out_rs_r;

    t_cur = temp_r[idx_r];
    v_cur = mask_r[idx_r];
    avg   = div_rsp.quotient[msfs_pkg::TEMP_W-1:0];
    if (sum_r[msfs_pkg::SUM_W-1]) begin
      avg = -avg;
    end
    ok   = (cnt_r >= msfs_pkg::MIN_VALID) && (!mode_fixed || fix_ok_r);
    fb   = '0;
    if (ok) begin
      fb = mode_avg ? avg : ext_r;
    end
    stop = !cfg.enable || !ok || ot_latch_r;
    gap  = tick_r - last_tick_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // Snapshots with sequence zero or a repeated sequence are dropped here.
        if (in_valid && (in_sequence_req != '0) && (in_sequence_req != last_round_r)) begin
          temp_nxt[0]    = in_temp_ch1;
          temp_nxt[1]    = in_temp_ch2;
          temp_nxt[2]    = in_temp_ch3;
          temp_nxt[3]    = in_temp_ch4;
          mask_nxt       = in_valid_mask;
          tick_nxt       = in_tick_ms;
          last_round_nxt = in_sequence_req;
          idx_nxt        = '0;
          cnt_nxt        = '0;
          sum_nxt        = '0;
          ext_nxt        = '0;
          fix_ok_nxt     = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (v_cur) begin
          cnt_nxt = cnt_r + 1'b1;
          sum_nxt = sum_r + msfs_pkg::SUM_W'(t_cur);
          if (t_cur >= cfg.threshold) begin
            ot_latch_nxt = 1'b1;
          end
          if ((cfg.mode == msfs_pkg::MODE_MAX) &&
              ((cnt_r == '0) || (t_cur > ext_r))) begin
            ext_nxt = t_cur;
          end
          if ((cfg.mode == msfs_pkg::MODE_MIN) &&
              ((cnt_r == '0) || (t_cur < ext_r))) begin
            ext_nxt = t_cur;
          end
        end
        if (mode_fixed && (idx_r == fix_ch)) begin
          ext_nxt    = t_cur;
          fix_ok_nxt = v_cur;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == msfs_pkg::CH_IDX_W'(msfs_pkg::NCH - 1)) begin
          if (mode_avg && (cnt_nxt >= msfs_pkg::MIN_VALID)) begin
            state_nxt = S_DIVST;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIVST: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok;
          out_fb_nxt    = fb;
          out_err_nxt   = ok ? (msfs_pkg::ERR_W'(cfg.setpoint) - msfs_pkg::ERR_W'(fb)) : '0;
          out_cnt_nxt   = cnt_r;
          if (stop) begin
            out_run_nxt = 1'b0;
            out_rst_nxt = 1'b1;
            out_int_nxt = '0;
          end else if (last_tick_r == '0) begin
            out_run_nxt = 1'b1;
            out_rst_nxt = 1'b0;
            out_int_nxt = msfs_pkg::NOMINAL_MS;
          end else if ((gap == '0) || (gap > msfs_pkg::MAX_GAP_MS)) begin
            out_run_nxt = 1'b1;
            out_rst_nxt = 1'b1;
            out_int_nxt = msfs_pkg::NOMINAL_MS;
          end else begin
            out_run_nxt = 1'b1;
            out_rst_nxt = 1'b0;
            out_int_nxt = gap[msfs_pkg::INT_W-1:0];
          end
          if (ot_latch_r) begin
            out_rs_nxt = msfs_pkg::RS_OVERTEMP;
          end else if (cfg.enable && ok) begin
            out_rs_nxt = msfs_pkg::RS_CONTROL;
          end else begin
            out_rs_nxt = msfs_pkg::RS_IDLE;
          end
          last_tick_nxt = tick_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_round_r <= '0;
      last_tick_r  <= '0;
      ot_latch_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_round_r <= last_round_nxt;
      last_tick_r  <= last_tick_nxt;
      ot_latch_r   <= ot_latch_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    temp_r    <= temp_nxt;
    mask_r    <= mask_nxt;
    tick_r    <= tick_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    sum_r     <= sum_nxt;
    ext_r     <= ext_nxt;
    fix_ok_r  <= fix_ok_nxt;
    out_run_r <= out_run_nxt;
    out_rst_r <= out_rst_nxt;
    out_ok_r  <= out_ok_nxt;
    out_fb_r  <= out_fb_nxt;
    out_err_r <= out_err_nxt;
    out_int_r <= out_int_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_rs_r  <= out_rs_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_run           = out_run_r;
  assign out_pid_clear     = out_rst_r;
  assign out_feedback_ok   = out_ok_r;
  assign out_feedback_temp = out_fb_r;
  assign out_control_error = out_err_r;
  assign out_interval_ms   = out_int_r;
  assign out_chan_count    = out_cnt_r;
  assign out_run_state     = out_rs_r;

  // The over-temperature latch clears only through reset.
  a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(ot_latch_r))
    else $error("over-temperature latch cleared without reset");

  // The latch may already be set by the next snapshot while a run result waits.
  a_run_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run |-> out_feedback_ok && out_interval_ms != '0 &&
      out_interval_ms <= msfs_pkg::INT_W'(10000))
    else $error("run result without valid feedback or with a bad interval");

  a_not_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_feedback_ok |-> out_feedback_temp == '0 && out_control_error == '0 &&
      out_run == 1'b0)
    else $error("feedback values reported although feedback is not ok");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy || div_rsp.done |-> state_r == S_DIV)
    else $error("divider active outside the wait state");

  a_latch_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_state == msfs_pkg::RS_OVERTEMP |-> ot_latch_r)
    else $error("over-temperature state reported without the latch");

endmodule
